FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// trigger in this cycle implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lcf_pkg.sv
// ----------------------------------------------------------------------------
// lcf_pkg
// Types and constants for the link ownership contest fence.
// ----------------------------------------------------------------------------
package lcf_pkg;

  localparam int FUNC_BITS      = 2;
  localparam int AGENT_BITS     = 6;
  localparam int VERDICT_BITS   = 3;
  localparam int COUNT_BITS     = 8;
  localparam int LINKED_BITS    = 7;
  localparam int THR_BITS       = 8;
  localparam int WIN_BITS       = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 8'd255;
  localparam logic [THR_BITS-1:0]   THR_RESET  = 8'd3;
  localparam logic [WIN_BITS-1:0]   WIN_RESET  = 16'd60;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_CONTEST_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_SECONDS    = 1'd1;

  // event kinds
  localparam logic [FUNC_BITS-1:0] FUNC_HELLO = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_CLOSE = 2'd1;

  // verdict codes
  localparam logic [VERDICT_BITS-1:0] V_ACCEPTED     = 3'd0;
  localparam logic [VERDICT_BITS-1:0] V_REPLACED     = 3'd1;
  localparam logic [VERDICT_BITS-1:0] V_REFUSED_AUTH = 3'd2;
  localparam logic [VERDICT_BITS-1:0] V_REFUSED_CONT = 3'd3;
  localparam logic [VERDICT_BITS-1:0] V_REMOVED      = 3'd4;
  localparam logic [VERDICT_BITS-1:0] V_CLOSE_IGN    = 3'd5;
  localparam logic [VERDICT_BITS-1:0] V_QUERY        = 3'd6;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_t;

endpackage

FILE: hdl/lcf_ram.sv
// ----------------------------------------------------------------------------
// lcf_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/link_ownership_contest_fence.sv
// ----------------------------------------------------------------------------
// link_ownership_contest_fence
// Per-agent link ownership table with a fixed-window displacement fence.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | in_tdata, in_tuser (func)
//  out_    | out | out_tvalid/out_tready | out_tdata
//  cfg_    | in  | cfg_wr_en             | cfg_index, cfg_wdata
//
// Each word is accepted with a RAM read, then modified and written back
// through the RAM write port in the lookup stage.
// After reset a clearing pass sweeps every RAM entry with in_tready low;
// configuration writes are taken during it.
// A result held by out_tready low keeps the next word waiting in the lookup
// stage; one further word may be accepted behind a waiting result.
// ----------------------------------------------------------------------------
module link_ownership_contest_fence
  import lcf_pkg::*;
#(
  parameter int AGENT_SLOTS   = 64,
  parameter int LINK_TAG_BITS = 16,
  parameter int TIME_BITS     = 32,
  localparam int IN_W         = AGENT_BITS + LINK_TAG_BITS + 1 + TIME_BITS,
  localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W        = VERDICT_BITS + 1 + LINK_TAG_BITS + 1 + COUNT_BITS + 1
                                + LINKED_BITS,
  localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // agent, link_tag, authorized, now_seconds
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_TDATA_W-1:0]     in_tdata,
  // func
  input  logic [FUNC_BITS-1:0]      in_tuser,
  // verdict, displaced_valid, displaced_tag, contested_pulse, live_count,
  // is_contested, linked_agents
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_W-1:0]    out_tdata,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int AW  = (AGENT_SLOTS > 1) ? $clog2(AGENT_SLOTS) : 1;
  // wide enough to hold AGENT_SLOTS itself for the range check
  localparam int AXW = (AW + 1 > AGENT_BITS) ? AW + 1 : AGENT_BITS;
  localparam int TW  = $clog2(AGENT_SLOTS + 1);

  typedef struct packed {
    logic                     linked;
    logic [LINK_TAG_BITS-1:0] tag;
    logic                     rvalid;
    logic [COUNT_BITS-1:0]    count;
    logic [TIME_BITS-1:0]     opened;
    logic                     announced;
  } entry_t;

  // input fields
  logic [FUNC_BITS-1:0]     in_func;
  logic [AGENT_BITS-1:0]    in_agent;
  logic [LINK_TAG_BITS-1:0] in_tag;
  logic                     in_auth;
  logic [TIME_BITS-1:0]     in_now;
  logic [AXW-1:0]           in_agent_x;
  logic                     in_fire;

  assign in_func    = in_tuser;
  assign in_agent   = in_tdata[AGENT_BITS-1:0];
  assign in_tag     = in_tdata[AGENT_BITS +: LINK_TAG_BITS];
  assign in_auth    = in_tdata[AGENT_BITS + LINK_TAG_BITS];
  assign in_now     = in_tdata[AGENT_BITS + LINK_TAG_BITS + 1 +: TIME_BITS];
  assign in_agent_x = AXW'(in_agent);
  assign in_fire    = in_tvalid && in_tready;

  // registers
  state_t                   state_r, state_nxt;
  logic [AW-1:0]            clr_idx_r, clr_idx_nxt;
  logic [THR_BITS-1:0]      thr_r;
  logic [WIN_BITS-1:0]      win_r;
  logic [TW-1:0]            total_r, total_nxt;
  logic [FUNC_BITS-1:0]     func_r;
  logic [AW-1:0]            addr_r;
  logic                     in_range_r;
  logic [LINK_TAG_BITS-1:0] tag_r;
  logic                     auth_r;
  logic [TIME_BITS-1:0]     now_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]   out_data_r, out_data_nxt;

  // RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;

  lcf_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (AGENT_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign ram_raddr  = (state_r == ST_IDLE) ? in_agent_x[AW-1:0] : addr_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // entry update
  entry_t                   e, e_new;
  logic                     out_free;
  logic [TIME_BITS-1:0]     diff;
  logic                     expired;
  logic [COUNT_BITS-1:0]    cnt_base, cnt_inc;
  logic [VERDICT_BITS-1:0]  verdict;
  logic                     dvalid, pulse, contested;
  logic [LINK_TAG_BITS-1:0] dtag;
  logic [COUNT_BITS-1:0]    live;
  logic                     live_ok;

  assign e        = ram_rdata;
  assign out_free = !out_valid_r || out_tready;
  assign diff     = now_r - e.opened;
  assign expired  = diff > TIME_BITS'(win_r);

  always_comb begin
    e_new     = e;
    verdict   = V_QUERY;
    dvalid    = 1'b0;
    dtag      = '0;
    pulse     = 1'b0;
    live      = '0;
    live_ok   = 1'b0;
    contested = 1'b0;
    total_nxt = total_r;
    cnt_base  = '0;
    cnt_inc   = '0;

    if (!in_range_r) begin
      if (func_r == FUNC_HELLO) begin
        verdict = V_REFUSED_AUTH;
      end else if (func_r == FUNC_CLOSE) begin
        verdict = V_CLOSE_IGN;
      end
    end else begin
      if (e.rvalid && !expired) begin
        live    = e.count;
        live_ok = 1'b1;
      end
      if (func_r == FUNC_HELLO) begin
        if (!auth_r) begin
          verdict = V_REFUSED_AUTH;
        end else if (e.linked && e.tag != tag_r) begin
          // displacement: fresh or expired record restarts the window
          if (e.rvalid && !expired) begin
            cnt_base = e.count;
          end else begin
            e_new.opened    = now_r;
            e_new.announced = 1'b0;
          end
          e_new.rvalid = 1'b1;
          cnt_inc      = (cnt_base < COUNT_MAX) ? cnt_base + 1'b1 : cnt_base;
          e_new.count  = cnt_inc;
          live         = cnt_inc;
          live_ok      = 1'b1;
          if (cnt_inc < thr_r) begin
            verdict   = V_REPLACED;
            dvalid    = 1'b1;
            dtag      = e.tag;
            e_new.tag = tag_r;
          end else begin
            verdict = V_REFUSED_CONT;
            if (!e_new.announced) begin
              e_new.announced = 1'b1;
              pulse           = 1'b1;
            end
          end
        end else begin
          verdict = V_ACCEPTED;
          if (!e.linked) begin
            e_new.linked = 1'b1;
            total_nxt    = total_r + 1'b1;
          end
          e_new.tag = tag_r;
        end
      end else if (func_r == FUNC_CLOSE) begin
        if (e.linked && e.tag == tag_r) begin
          e_new.linked = 1'b0;
          e_new.rvalid = 1'b0;
          live         = '0;
          live_ok      = 1'b0;
          if (total_r != '0) begin
            total_nxt = total_r - 1'b1;
          end
          verdict = V_REMOVED;
        end else begin
          verdict = V_CLOSE_IGN;
        end
      end
      // only a live record can be contested
      contested = live_ok && (live >= thr_r);
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = e_new;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        ram_wdata   = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == AW'(AGENT_SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (out_free) begin
          ram_we        = in_range_r;
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'({LINKED_BITS'(total_nxt), contested, live, pulse,
                                        dtag, dvalid, verdict});
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      thr_r       <= THR_RESET;
      win_r       <= WIN_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_LOOK && out_free) begin
        total_r <= total_nxt;
      end
      if (cfg_wr_en) begin
        if (cfg_index == REG_CONTEST_THRESHOLD) begin
          thr_r <= cfg_wdata[THR_BITS-1:0];
        end else if (cfg_index == REG_WINDOW_SECONDS) begin
          win_r <= cfg_wdata[WIN_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      func_r     <= in_func;
      addr_r     <= in_agent_x[AW-1:0];
      in_range_r <= (in_agent_x < AXW'(AGENT_SLOTS));
      tag_r      <= in_tag;
      auth_r     <= in_auth;
      now_r      <= in_now;
    end
  end

endmodule

FILE: hdl/lcf_checker.sv
// ----------------------------------------------------------------------------
// lcf_checker
// Port-level checks for the link ownership contest fence, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcf_checker
  import lcf_pkg::*;
#(
  parameter int LINK_TAG_BITS = 16,
  parameter int IN_TDATA_W    = 56,
  parameter int OUT_TDATA_W   = 40
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int DVALID_POS = VERDICT_BITS;
  localparam int PULSE_POS  = VERDICT_BITS + 1 + LINK_TAG_BITS;
  localparam int CONT_POS   = PULSE_POS + 1 + COUNT_BITS;

  logic [VERDICT_BITS-1:0] verdict;
  logic                    dvalid, pulse, contested;

  assign verdict   = out_tdata[VERDICT_BITS-1:0];
  assign dvalid    = out_tdata[DVALID_POS];
  assign pulse     = out_tdata[PULSE_POS];
  assign contested = out_tdata[CONT_POS];

  // one word in flight through the lookup: no back-to-back accepts
  `ASSERT_NEXT(a_in_gap, clk, rst_n, in_tvalid && in_tready, !in_tready, "accept too soon")

  `ASSERT_ALWAYS(a_disp_match, clk, rst_n, !out_tvalid || (dvalid == (verdict == V_REPLACED)), "displaced flag mismatch")

  `ASSERT_ALWAYS(a_pulse, clk, rst_n, !(out_tvalid && pulse) || (verdict == V_REFUSED_CONT && contested), "pulse without contest")

  `ASSERT_ALWAYS(a_verdict, clk, rst_n, !out_tvalid || verdict <= V_QUERY, "bad verdict code")

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled word changed")

endmodule

bind link_ownership_contest_fence lcf_checker #(
  .LINK_TAG_BITS (LINK_TAG_BITS),
  .IN_TDATA_W    (IN_TDATA_W),
  .OUT_TDATA_W   (OUT_TDATA_W)
) u_lcf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
